// ===== hdl/mas_pkg.sv =====
package mas_pkg;

    localparam int unsigned LEVEL_W       = 24;
    localparam int unsigned SEC_W         = 32;
    localparam int unsigned US_W          = 48;
    localparam int unsigned DELAY_W       = 16;
    localparam int unsigned COUNT_W       = 8;
    localparam int unsigned CFG_INDEX_W   = 3;
    localparam int unsigned CFG_DATA_W    = 24;
    localparam int unsigned STATE_W       = 2;
    // 255 s * 1e6 us fits in 28 bits
    localparam int unsigned WINDOW_US_W   = 28;
    localparam int unsigned US_PER_SECOND = 1000000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MOTION_THRESHOLD = 3'd0,
        REG_PRE_WATCH_DELAY  = 3'd1,
        REG_POST_ALARM_DELAY = 3'd2,
        REG_STABLE_WINDOW    = 3'd3,
        REG_STABLE_FRAMES    = 3'd4,
        REG_MIN_ALARM        = 3'd5,
        REG_MAX_ALARM        = 3'd6
    } cfg_index_t;

    typedef enum logic {
        OP_FRAME   = 1'b0,
        OP_RESTART = 1'b1
    } op_t;

    // Register file contents as seen by the sequencer
    typedef struct packed {
        logic [LEVEL_W-1:0]     motion_threshold;
        logic [DELAY_W-1:0]     pre_watch_delay;
        logic [DELAY_W-1:0]     post_alarm_delay;
        logic [WINDOW_US_W-1:0] window_us;
        logic [COUNT_W-1:0]     stable_frame_count;
        logic [DELAY_W-1:0]     min_alarm_seconds;
        logic [DELAY_W-1:0]     max_alarm_seconds;
    } cfg_t;

    typedef struct packed {
        logic               operation;
        logic [LEVEL_W-1:0] motion_level;
        logic [SEC_W-1:0]   now_seconds;
        logic [US_W-1:0]    now_microseconds;
    } item_t;

    typedef struct packed {
        logic [STATE_W-1:0] detector_state;
        logic [COUNT_W-1:0] motion_frames;
        logic [SEC_W-1:0]   alarm_end_seconds;
    } result_t;

    // a + b, clamped at all ones
    function automatic logic [SEC_W-1:0] sat_add(
        input logic [SEC_W-1:0]   a,
        input logic [DELAY_W-1:0] b
    );
        logic [SEC_W:0] sum;
        begin
            sum = {1'b0, a} + {{(SEC_W-DELAY_W+1){1'b0}}, b};
            sat_add = sum[SEC_W] ? {SEC_W{1'b1}} : sum[SEC_W-1:0];
        end
    endfunction

endpackage

// ===== hdl/mas_if.sv =====
interface mas_cfg_if;
    import mas_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

interface mas_in_if;
    import mas_pkg::*;

    logic               valid;
    logic               ready;
    logic               operation;
    logic [LEVEL_W-1:0] motion_level;
    logic [SEC_W-1:0]   now_seconds;
    logic [US_W-1:0]    now_microseconds;

    modport source (
        output valid, output operation, output motion_level,
        output now_seconds, output now_microseconds, input ready
    );
    modport sink (
        input valid, input operation, input motion_level,
        input now_seconds, input now_microseconds, output ready
    );
endinterface

interface mas_out_if;
    import mas_pkg::*;

    logic               valid;
    logic               ready;
    logic [STATE_W-1:0] detector_state;
    logic [COUNT_W-1:0] motion_frames;
    logic [SEC_W-1:0]   alarm_end_seconds;

    modport source (
        output valid, output detector_state, output motion_frames,
        output alarm_end_seconds, input ready
    );
    modport sink (
        input valid, input detector_state, input motion_frames,
        input alarm_end_seconds, output ready
    );
endinterface

// ===== hdl/motion_alarm_sequencer_core.sv =====
// Motion alarm sequencer. Each transfer on frame is a frame event (motion
// level, time in seconds, free-running microsecond count) or a stream
// restart; each produces exactly one transfer on result carrying the
// sequencer state, the motion frame count of the current window and the
// alarm segment end time, all as they stand after that item. Throughput is
// one item per clock while result.ready is high: an item passes through the
// input register, the state update (compares, a 48-bit window subtract,
// saturating 32-bit adds) is combinational and the updated state registers
// are the result. The item waits there until the result slot is free or
// drained; then the state registers and result valid load together. While a
// result is held off by result.ready low, one more item is taken into the
// input register, then frame.ready drops. Configuration writes on cfg are
// always taken (cfg.ready tied high) and must be done while no item is in
// flight; indexes above six are ignored. The stable window register is
// converted to microseconds on write.
module motion_alarm_sequencer_core (
    input  logic      clk,
    input  logic      rst_n,
    mas_cfg_if.sink   cfg,
    mas_in_if.sink    frame,
    mas_out_if.source result
);
    import mas_pkg::*;

    cfg_t    regs;
    result_t res;

    logic    in_valid_reg, in_valid_next;
    item_t   in_item_reg;
    logic    out_valid_reg, out_valid_next;
    logic    frame_xfer;
    logic    advance;

    // register file, window pre-scaled to microseconds
    mas_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    // sequencer state and next-state logic
    mas_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .regs  (regs),
        .step  (advance),
        .item  (in_item_reg),
        .res   (res)
    );

    // An item is processed when the result slot is free or being drained.
    // The state registers then stay frozen until the result transfers.
    assign advance     = in_valid_reg && (!out_valid_reg || result.ready);
    assign frame.ready = !in_valid_reg || advance;
    assign frame_xfer  = frame.valid && frame.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (frame_xfer)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload register, no reset needed
    always_ff @(posedge clk)
    begin
        if (frame_xfer)
        begin
            in_item_reg.operation        <= frame.operation;
            in_item_reg.motion_level     <= frame.motion_level;
            in_item_reg.now_seconds      <= frame.now_seconds;
            in_item_reg.now_microseconds <= frame.now_microseconds;
        end
    end

    assign result.valid             = out_valid_reg;
    assign result.detector_state    = res.detector_state;
    assign result.motion_frames     = res.motion_frames;
    assign result.alarm_end_seconds = res.alarm_end_seconds;

endmodule

// ===== hdl/mas_cfg.sv =====
module mas_cfg (
    input  logic          clk,
    input  logic          rst_n,
    mas_cfg_if.sink       cfg,
    output mas_pkg::cfg_t regs
);
    import mas_pkg::*;

    cfg_t                   regs_reg;
    cfg_t                   regs_next;
    logic [WINDOW_US_W-1:0] window_us;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    // window length converted to microseconds once, at write time
    assign window_us = WINDOW_US_W'(cfg.data[COUNT_W-1:0])
                     * WINDOW_US_W'(US_PER_SECOND);

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg_index_t'(cfg.index))
                REG_MOTION_THRESHOLD: regs_next.motion_threshold = cfg.data;
                REG_PRE_WATCH_DELAY:  regs_next.pre_watch_delay  = cfg.data[DELAY_W-1:0];
                REG_POST_ALARM_DELAY: regs_next.post_alarm_delay = cfg.data[DELAY_W-1:0];
                REG_STABLE_WINDOW:    regs_next.window_us        = window_us;
                REG_STABLE_FRAMES:    regs_next.stable_frame_count = cfg.data[COUNT_W-1:0];
                REG_MIN_ALARM:        regs_next.min_alarm_seconds = cfg.data[DELAY_W-1:0];
                REG_MAX_ALARM:        regs_next.max_alarm_seconds = cfg.data[DELAY_W-1:0];
                default:              regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.motion_threshold   <= '0;
            regs_reg.pre_watch_delay    <= '0;
            regs_reg.post_alarm_delay   <= '0;
            regs_reg.window_us          <= WINDOW_US_W'(US_PER_SECOND);
            regs_reg.stable_frame_count <= COUNT_W'(1);
            regs_reg.min_alarm_seconds  <= '0;
            regs_reg.max_alarm_seconds  <= '0;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

// ===== hdl/mas_seq.sv =====
module mas_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  mas_pkg::cfg_t    regs,
    input  logic             step,
    input  mas_pkg::item_t   item,
    output mas_pkg::result_t res
);
    import mas_pkg::*;

    typedef enum logic [STATE_W-1:0] {
        MODE_IDLE      = 2'd0,
        MODE_WAITING   = 2'd1,
        MODE_VIGILANT  = 2'd2,
        MODE_TRIGGERED = 2'd3
    } mode_t;

    mode_t              mode_reg, mode_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [SEC_W-1:0]   watch_reg, watch_next;
    logic [SEC_W-1:0]   started_reg, started_next;
    logic [SEC_W-1:0]   ends_reg, ends_next;
    logic [US_W-1:0]    win_reg, win_next;

    logic               motion;
    logic [US_W-1:0]    win_start;
    logic [US_W-1:0]    elapsed;
    logic               in_window;
    logic [COUNT_W-1:0] count_inc;
    logic [SEC_W-1:0]   by_min, by_max, seg_end;

    assign motion    = item.motion_level > regs.motion_threshold;
    assign win_start = (count_reg == '0) ? item.now_microseconds : win_reg;
    assign elapsed   = item.now_microseconds - win_start;
    assign in_window = elapsed < {{(US_W-WINDOW_US_W){1'b0}}, regs.window_us};
    assign count_inc = (count_reg == {COUNT_W{1'b1}}) ? count_reg : count_reg + 1'b1;

    // on a trigger the segment start is this frame's time
    assign by_min  = sat_add(item.now_seconds, regs.min_alarm_seconds);
    assign by_max  = sat_add((mode_reg == MODE_VIGILANT) ? item.now_seconds : started_reg,
                             regs.max_alarm_seconds);
    assign seg_end = (by_min < by_max) ? by_min : by_max;

    always_comb
    begin
        mode_next    = mode_reg;
        count_next   = count_reg;
        watch_next   = watch_reg;
        started_next = started_reg;
        ends_next    = ends_reg;
        win_next     = win_reg;
        if (item.operation == OP_RESTART)
        begin
            mode_next    = MODE_IDLE;
            count_next   = '0;
            watch_next   = '0;
            started_next = '0;
            ends_next    = '0;
            win_next     = '0;
        end
        else
        begin
            case (mode_reg)
                MODE_IDLE:
                begin
                    watch_next = sat_add(item.now_seconds, regs.pre_watch_delay);
                    mode_next  = MODE_WAITING;
                end
                MODE_WAITING:
                begin
                    if (item.now_seconds > watch_reg)
                        mode_next = MODE_VIGILANT;
                end
                MODE_VIGILANT:
                begin
                    if (motion)
                    begin
                        if (in_window)
                        begin
                            if (count_inc >= regs.stable_frame_count)
                            begin
                                count_next   = '0;
                                win_next     = '0;
                                started_next = item.now_seconds;
                                ends_next    = seg_end;
                                mode_next    = MODE_TRIGGERED;
                            end
                            else
                            begin
                                count_next = count_inc;
                                win_next   = win_start;
                            end
                        end
                        else
                        begin
                            count_next = '0;
                            win_next   = '0;
                            ends_next  = '0;
                        end
                    end
                end
                default:
                begin
                    if (item.now_seconds > ends_reg)
                    begin
                        watch_next = sat_add(item.now_seconds, regs.post_alarm_delay);
                        mode_next  = MODE_WAITING;
                    end
                    else if (motion)
                    begin
                        ends_next = seg_end;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            count_reg   <= '0;
            watch_reg   <= '0;
            started_reg <= '0;
            ends_reg    <= '0;
            win_reg     <= '0;
        end
        else if (step)
        begin
            mode_reg    <= mode_next;
            count_reg   <= count_next;
            watch_reg   <= watch_next;
            started_reg <= started_next;
            ends_reg    <= ends_next;
            win_reg     <= win_next;
        end
    end

    // state after the latest step is the result
    assign res.detector_state    = mode_reg;
    assign res.motion_frames     = count_reg;
    assign res.alarm_end_seconds = ends_reg;

endmodule

// ===== test/motion_alarm_sequencer_checker.sv =====
module motion_alarm_sequencer_checker (
    input  logic        clk,
    input  logic        rst_n,
    mas_cfg_if          cfg,
    mas_in_if           frame,
    mas_out_if          result,
    output int unsigned errors,
    output int unsigned in_flight
);
    timeunit 1ns;
    timeprecision 1ps;

    import mas_pkg::*;

    typedef enum logic [STATE_W-1:0] {
        SEQ_IDLE      = 2'd0,
        SEQ_WAITING   = 2'd1,
        SEQ_VIGILANT  = 2'd2,
        SEQ_TRIGGERED = 2'd3
    } seq_mode_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] threshold;
        logic [DELAY_W-1:0] pre_delay;
        logic [DELAY_W-1:0] post_delay;
        logic [COUNT_W-1:0] window_s;
        logic [COUNT_W-1:0] frames_needed;
        logic [DELAY_W-1:0] min_s;
        logic [DELAY_W-1:0] max_s;
    } alarm_settings_t;

    typedef struct packed {
        seq_mode_t          mode;
        logic [COUNT_W-1:0] count;
        logic [SEC_W-1:0]   watch_at;
        logic [SEC_W-1:0]   started_at;
        logic [SEC_W-1:0]   ends_at;
        logic [US_W-1:0]    window_start;
    } seq_state_t;

    alarm_settings_t settings;
    seq_state_t      seq;
    result_t         expected_reports[$];

    // time plus delay, pinned at all ones on overflow
    function automatic logic [SEC_W-1:0] clamp_add(
        input logic [SEC_W-1:0]   base,
        input logic [DELAY_W-1:0] delay
    );
        logic [SEC_W:0] total;
        total = {1'b0, base} + {{(SEC_W-DELAY_W+1){1'b0}}, delay};
        return total[SEC_W] ? {SEC_W{1'b1}} : total[SEC_W-1:0];
    endfunction

    // end of segment: min length past now, capped by max length from trigger
    function automatic logic [SEC_W-1:0] alarm_deadline(input logic [SEC_W-1:0] now);
        logic [SEC_W-1:0] by_min;
        logic [SEC_W-1:0] by_max;
        by_min = clamp_add(now, settings.min_s);
        by_max = clamp_add(seq.started_at, settings.max_s);
        return (by_min < by_max) ? by_min : by_max;
    endfunction

    function automatic void apply_write(
        input logic [CFG_INDEX_W-1:0] index,
        input logic [CFG_DATA_W-1:0]  data
    );
        case (index)
            REG_MOTION_THRESHOLD: settings.threshold     = data[LEVEL_W-1:0];
            REG_PRE_WATCH_DELAY:  settings.pre_delay     = data[DELAY_W-1:0];
            REG_POST_ALARM_DELAY: settings.post_delay    = data[DELAY_W-1:0];
            REG_STABLE_WINDOW:    settings.window_s      = data[COUNT_W-1:0];
            REG_STABLE_FRAMES:    settings.frames_needed = data[COUNT_W-1:0];
            REG_MIN_ALARM:        settings.min_s         = data[DELAY_W-1:0];
            REG_MAX_ALARM:        settings.max_s         = data[DELAY_W-1:0];
            default: ;
        endcase
    endfunction

    // advance the sequencer by one item and queue the report it yields
    function automatic void apply_item(input item_t it);
        logic            motion;
        logic [US_W-1:0] elapsed;
        logic [US_W-1:0] window_len;
        result_t         report;
        motion = it.motion_level > settings.threshold;
        if (op_t'(it.operation) == OP_RESTART) begin
            seq = '0;
        end else begin
            case (seq.mode)
                SEQ_IDLE:
                begin
                    seq.watch_at = clamp_add(it.now_seconds, settings.pre_delay);
                    seq.mode     = SEQ_WAITING;
                end
                SEQ_WAITING:
                begin
                    if (it.now_seconds > seq.watch_at)
                        seq.mode = SEQ_VIGILANT;
                end
                SEQ_VIGILANT:
                begin
                    if (motion) begin
                        if (seq.count == '0)
                            seq.window_start = it.now_microseconds;
                        elapsed    = it.now_microseconds - seq.window_start;
                        window_len = US_W'(settings.window_s) * US_W'(US_PER_SECOND);
                        if (elapsed < window_len) begin
                            if (seq.count != {COUNT_W{1'b1}})
                                seq.count++;
                            if (seq.count >= settings.frames_needed) begin
                                seq.count        = '0;
                                seq.window_start = '0;
                                seq.started_at   = it.now_seconds;
                                seq.ends_at      = alarm_deadline(it.now_seconds);
                                seq.mode         = SEQ_TRIGGERED;
                            end
                        end else begin
                            seq.window_start = '0;
                            seq.ends_at      = '0;
                            seq.count        = '0;
                        end
                    end
                end
                default:
                begin
                    if (it.now_seconds > seq.ends_at) begin
                        seq.watch_at = clamp_add(it.now_seconds, settings.post_delay);
                        seq.mode     = SEQ_WAITING;
                    end else if (motion) begin
                        seq.ends_at = alarm_deadline(it.now_seconds);
                    end
                end
            endcase
        end
        report.detector_state    = seq.mode;
        report.motion_frames     = seq.count;
        report.alarm_end_seconds = seq.ends_at;
        expected_reports.push_back(report);
    endfunction

    function automatic void check_report(input result_t got);
        result_t want;
        if (expected_reports.size() == 0) begin
            errors++;
            $display("%0t: result transfer with none expected, got state %0d frames %0d end %0d",
                     $time, got.detector_state, got.motion_frames, got.alarm_end_seconds);
            return;
        end
        want = expected_reports.pop_front();
        if (got.detector_state !== want.detector_state) begin
            errors++;
            $display("%0t: detector_state expected %0d, got %0d",
                     $time, want.detector_state, got.detector_state);
        end
        if (got.motion_frames !== want.motion_frames) begin
            errors++;
            $display("%0t: motion_frames expected %0d, got %0d",
                     $time, want.motion_frames, got.motion_frames);
        end
        if (got.alarm_end_seconds !== want.alarm_end_seconds) begin
            errors++;
            $display("%0t: alarm_end_seconds expected %0d, got %0d",
                     $time, want.alarm_end_seconds, got.alarm_end_seconds);
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        int unsigned taken;
        int unsigned returned;
        if (!rst_n) begin
            settings               = '0;
            settings.window_s      = 8'd1;
            settings.frames_needed = 8'd1;
            seq                    = '0;
            expected_reports.delete();
            errors                 = 0;
            in_flight             <= 0;
        end else begin
            taken    = 0;
            returned = 0;
            if (cfg.valid && cfg.ready)
                apply_write(cfg.index, cfg.data);
            if (frame.valid && frame.ready) begin
                apply_item({frame.operation, frame.motion_level,
                            frame.now_seconds, frame.now_microseconds});
                taken = 1;
            end
            if (result.valid && result.ready) begin
                if (expected_reports.size() != 0)
                    returned = 1;
                check_report({result.detector_state, result.motion_frames,
                              result.alarm_end_seconds});
            end
            in_flight <= in_flight + taken - returned;
        end
    end

endmodule

// ===== test/motion_alarm_sequencer_core_tb.sv =====
module motion_alarm_sequencer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mas_pkg::*;

    // Index past the register file; writes to it must be dropped
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
    // Margin after the last result before touching config
    localparam int unsigned SETTLE_CYCLES = 4;

    localparam int unsigned CFG_ZERO = 0;
    localparam int unsigned CFG_FULL = 1;

    logic clk = 1'b0;
    logic rst_n;

    mas_cfg_if cfg_bus();
    mas_in_if  frame_bus();
    mas_out_if result_bus();

    int unsigned errors;
    int unsigned in_flight;

    // Stimulus-side model of wall time: seconds and the free-running us count
    logic [SEC_W-1:0]   clock_s;
    logic [US_W-1:0]    clock_us;
    int unsigned        frac_us;
    // Current motion threshold, so frames can be aimed above or below it
    logic [LEVEL_W-1:0] cut;

    // No stalls on either side once set (tail end of the run)
    bit          calm;
    int unsigned hold_left;

    always #1 clk = ~clk;

    motion_alarm_sequencer_core DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus),
        .frame  (frame_bus),
        .result (result_bus)
    );

    motion_alarm_sequencer_checker scoreboard (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_bus),
        .frame     (frame_bus),
        .result    (result_bus),
        .errors    (errors),
        .in_flight (in_flight)
    );

    // Result backpressure: random bursts of ready held low
    always @(posedge clk) begin
        if (calm) begin
            result_bus.ready <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left        <= hold_left - 1;
            result_bus.ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            hold_left        <= $urandom_range(0, 4);
            result_bus.ready <= 1'b0;
        end else begin
            result_bus.ready <= 1'b1;
        end
    end

    function automatic logic [US_W-1:0] any_us();
        return US_W'({$urandom(), $urandom()});
    endfunction

    // One config transfer. valid is left high; the caller drops it after
    // the last write so back-to-back writes never toggle it within a step.
    task automatic write_reg(
        input logic [CFG_INDEX_W-1:0] index,
        input logic [CFG_DATA_W-1:0]  data
    );
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= index;
        cfg_bus.data  <= data;
        do @(posedge clk); while (!cfg_bus.ready);
    endtask

    // One frame transfer, then sometimes a gap with valid low
    task automatic push_frame(
        input op_t                op,
        input logic [LEVEL_W-1:0] level,
        input logic [SEC_W-1:0]   sec,
        input logic [US_W-1:0]    us
    );
        frame_bus.valid            <= 1'b1;
        frame_bus.operation        <= op;
        frame_bus.motion_level     <= level;
        frame_bus.now_seconds      <= sec;
        frame_bus.now_microseconds <= us;
        do @(posedge clk); while (!frame_bus.ready);
        if (!calm && $urandom_range(0, 4) == 0) begin
            frame_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    // Hold the sender until every queued result is back. The first wait
    // lets the count pick up an item taken in the current step.
    task automatic settle();
        frame_bus.valid <= 1'b0;
        do @(posedge clk); while (in_flight != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // All registers at one extreme, plus a write to the dead index
    task automatic program_extreme(input int unsigned style);
        logic [CFG_DATA_W-1:0] value;
        value = (style == CFG_FULL) ? {CFG_DATA_W{1'b1}} : '0;
        for (int i = REG_MOTION_THRESHOLD; i <= REG_MAX_ALARM; i++)
            write_reg(CFG_INDEX_W'(i), value);
        write_reg(REG_UNUSED, ~value);
        cfg_bus.valid <= 1'b0;
        cut = value[LEVEL_W-1:0];
    endtask

    // Short delays and windows so every state is visited; upper data bits
    // beyond each register's width are random and must be ignored.
    task automatic program_typical();
        logic [LEVEL_W-1:0] threshold;
        threshold = LEVEL_W'($urandom);
        write_reg(REG_MOTION_THRESHOLD, threshold);
        write_reg(REG_PRE_WATCH_DELAY, {8'($urandom), 16'($urandom_range(0, 4))});
        write_reg(REG_POST_ALARM_DELAY, {8'($urandom), 16'($urandom_range(0, 4))});
        write_reg(REG_STABLE_WINDOW, {16'($urandom), 8'($urandom_range(1, 4))});
        write_reg(REG_STABLE_FRAMES, {16'($urandom), 8'($urandom_range(0, 5))});
        write_reg(REG_MIN_ALARM, {8'($urandom),
                  16'(($urandom_range(0, 4) == 0) ? 65535 : $urandom_range(0, 8))});
        write_reg(REG_MAX_ALARM, {8'($urandom),
                  16'(($urandom_range(0, 4) == 0) ? 65535 : $urandom_range(0, 15))});
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        cfg_bus.valid <= 1'b0;
        cut = threshold;
    endtask

    // Frame interval mostly under half a second, now and then a jump
    task automatic tick_clock();
        int unsigned step;
        if ($urandom_range(0, 9) == 0)
            step = $urandom_range(1000000, 8000000);
        else
            step = $urandom_range(0, 400000);
        clock_us = clock_us + step;
        frac_us  = frac_us + step;
        clock_s  = clock_s + frac_us / 1000000;
        frac_us  = frac_us % 1000000;
    endtask

    // Mostly time-consistent frames aimed around the threshold; a few
    // restarts and frames with random time fields to break sequences.
    task automatic run_traffic(input int unsigned count);
        int unsigned        pick;
        logic [LEVEL_W-1:0] level;
        push_frame(OP_RESTART, LEVEL_W'($urandom), $urandom, any_us());
        if ($urandom_range(0, 2) == 0)
            clock_s = 32'hFFFF_FFFF - $urandom_range(0, 40);
        else
            clock_s = $urandom;
        clock_us = any_us();
        frac_us  = 0;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                push_frame(OP_RESTART, LEVEL_W'($urandom), $urandom, any_us());
            end else if (pick < 8) begin
                push_frame(OP_FRAME, LEVEL_W'($urandom), $urandom, any_us());
            end else begin
                tick_clock();
                if ($urandom_range(0, 9) < 6 && cut != {LEVEL_W{1'b1}})
                    level = LEVEL_W'($urandom_range(cut + 1, {LEVEL_W{1'b1}}));
                else
                    level = LEVEL_W'($urandom_range(0, cut));
                push_frame(OP_FRAME, level, clock_s, clock_us);
            end
        end
    endtask

    initial begin
        rst_n                       <= 1'b0;
        calm                        <= 1'b0;
        cfg_bus.valid               <= 1'b0;
        cfg_bus.index               <= '0;
        cfg_bus.data                <= '0;
        frame_bus.valid             <= 1'b0;
        frame_bus.operation         <= OP_FRAME;
        frame_bus.motion_level      <= '0;
        frame_bus.now_seconds       <= '0;
        frame_bus.now_microseconds  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed walk: threshold 1000, pre 5 s, post 3 s, window 2 s,
        // 3 frames to trigger, alarm 4 s past motion, at most 10 s.
        write_reg(REG_MOTION_THRESHOLD, 24'd1000);
        write_reg(REG_PRE_WATCH_DELAY, 24'd5);
        write_reg(REG_POST_ALARM_DELAY, 24'd3);
        write_reg(REG_STABLE_WINDOW, 24'd2);
        write_reg(REG_STABLE_FRAMES, 24'd3);
        write_reg(REG_MIN_ALARM, 24'd4);
        write_reg(REG_MAX_ALARM, 24'd10);
        write_reg(REG_UNUSED, {CFG_DATA_W{1'b1}});
        cfg_bus.valid <= 1'b0;
        cut = 24'd1000;

        // restart with every other field at its maximum
        push_frame(OP_RESTART, '1, '1, '1);
        // pre-watch sum saturates at the top of the seconds range
        push_frame(OP_FRAME, '0, 32'hFFFF_FFFE, '0);
        push_frame(OP_FRAME, '1, 32'hFFFF_FFFF, '1);
        push_frame(OP_RESTART, '0, '0, '0);
        // idle frame arms the delay, waiting until strictly past it
        push_frame(OP_FRAME, '0, 32'd10, 48'd0);
        push_frame(OP_FRAME, '1, 32'd15, 48'd100);
        push_frame(OP_FRAME, '0, 32'd16, 48'd200);
        // level equal to the threshold is not motion
        push_frame(OP_FRAME, 24'd1000, 32'd16, 48'd300);
        // window opens just before the us counter wraps and survives it
        push_frame(OP_FRAME, 24'd1001, 32'd16, 48'hFFFF_FFFF_0000);
        push_frame(OP_FRAME, '1, 32'd16, 48'h0000_0000_1000);
        // motion past the window end clears the count and end time
        push_frame(OP_FRAME, 24'd5000, 32'd16, 48'h0000_0000_1000 + 48'd3000000);
        push_frame(OP_FRAME, 24'd5000, 32'd17, 48'd5000000);
        push_frame(OP_FRAME, 24'd5000, 32'd17, 48'd5500000);
        // third frame in the window triggers; end = min(now+4, start+10)
        push_frame(OP_FRAME, 24'd5000, 32'd17, 48'd6000000);
        push_frame(OP_FRAME, 24'd5000, 32'd20, 48'd9000000);
        // extension now capped by the maximum length
        push_frame(OP_FRAME, 24'd5000, 32'd24, 48'd13000000);
        push_frame(OP_FRAME, '0, 32'd27, 48'd16000000);
        // expiry arms the post delay; stale end time stays visible
        push_frame(OP_FRAME, '0, 32'd28, 48'd17000000);
        push_frame(OP_FRAME, 24'd5000, 32'd31, 48'd20000000);
        push_frame(OP_FRAME, 24'd5000, 32'd32, 48'd21000000);
        push_frame(OP_RESTART, 24'd5000, 32'd33, 48'd22000000);
        settle();

        // Zero window: nothing is ever counted; zero frames needed too
        program_extreme(CFG_ZERO);
        run_traffic(50);
        settle();

        // Everything at full scale: nothing exceeds the threshold
        program_extreme(CFG_FULL);
        run_traffic(30);
        settle();

        repeat (5) begin
            program_typical();
            run_traffic(85);
            settle();
        end

        // last stretch runs at full rate with no stalls
        calm <= 1'b1;
        program_typical();
        run_traffic(85);
        settle();

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #400000;
        $display("FAIL");
        $finish;
    end

endmodule
